>>> rtl/hnht_pkg.sv
// hnht_pkg: shared sizes, codes and request/result types for the
// hamming nearest-hash search block. No dependencies.
`timescale 1ns / 1ps

package hnht_pkg;

  // table and search sizing
  localparam int TABLE_DEPTH    = 1024;
  localparam int MAX_CANDIDATES = 20;
  localparam int HASH_BITS      = 64;

  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int DIST_SLOTS = HASH_BITS + 1;
  localparam int DIST_W     = $clog2(DIST_SLOTS + 1);
  localparam int CAND_W     = $clog2(MAX_CANDIDATES + 1);

  // operation codes
  typedef logic [1:0] func_t;
  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_APPEND = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_MATCH    = 2'd0;
  localparam status_t ST_DONE_ACK = 2'd1;
  localparam status_t ST_NO_MATCH = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // request payload
  typedef struct packed {
    func_t                func;
    logic [HASH_BITS-1:0] hash_value;
  } req_t;

  // result payload
  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [DIST_W-1:0] distance;
    status_t           status;
    logic              last;
  } res_t;

endpackage

>>> rtl/hnht_dist.sv
// hnht_dist: two-stage pipelined hamming distance unit (xor + popcount).
// Depends on hnht_pkg for widths.
`timescale 1ns / 1ps

module hnht_dist
  import hnht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [HASH_BITS-1:0] a,
  input  logic [HASH_BITS-1:0] b,
  input  logic [IDX_W-1:0]     tag_in,
  output logic                 valid_out,
  output logic [DIST_W-1:0]    dist_out,
  output logic [IDX_W-1:0]     tag_out,
  output logic                 busy
);

  localparam int NUM_BYTES = (HASH_BITS + 7) / 8;

  logic [NUM_BYTES*8-1:0] diff;
  logic [3:0]             byte_cnt_next [NUM_BYTES];
  logic [3:0]             byte_cnt      [NUM_BYTES];
  logic                   valid_a;
  logic [IDX_W-1:0]       tag_a;
  logic [DIST_W-1:0]      total;

  // per-byte popcount of the differing bits
  always_comb begin
    diff = (NUM_BYTES*8)'(a ^ b);
    for (int k = 0; k < NUM_BYTES; k++) begin
      byte_cnt_next[k] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt_next[k] = byte_cnt_next[k] + 4'(diff[k*8+j]);
      end
    end
  end

  // sum of byte counts
  always_comb begin
    total = '0;
    for (int k = 0; k < NUM_BYTES; k++) begin
      total = total + DIST_W'(byte_cnt[k]);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid_a   <= valid_in;
      valid_out <= valid_a;
    end
    byte_cnt <= byte_cnt_next;
    tag_a    <= tag_in;
    dist_out <= total;
    tag_out  <= tag_a;
  end

  assign busy = valid_a | valid_out;

endmodule

>>> rtl/hamming_nearest_hash_topk.sv
// hamming_nearest_hash_topk: hash table with clear/append/query and
// nearest-by-hamming-distance result listing. Depends on hnht_pkg, hnht_dist.
`timescale 1ns / 1ps

// channel  | handshake            | payload
// request  | req_valid/req_ready  | req (req_t: func, hash_value)
// result   | res_valid/res_ready  | res (res_t: entry_index, distance, status, last)
//
// Clear, append and query on an empty table pass through the flush state,
// which waits while the result output stalls. A query scans all stored
// entries through the shared distance unit (one table read per cycle), then
// steps through the distance slots (65), emitting at most 20 results.
// Reset is synchronous and clears the entry count and control; stored hashes
// are not cleared. Requests are taken only between items; a stalled result
// output holds the emit sequencer.

module hamming_nearest_hash_topk
  import hnht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_LOOK,
    S_READ,
    S_FLUSH
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     entry_count;
  logic [CNT_W-1:0]     rd_addr;
  logic [HASH_BITS-1:0] query;
  logic [DIST_W-1:0]    slot;
  logic [CAND_W-1:0]    n_held;
  res_t                 held;
  logic                 held_valid;

  // table memory
  logic [HASH_BITS-1:0] hash_store [TABLE_DEPTH];
  logic [HASH_BITS-1:0] rd_data;
  logic                 rd_en;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 wr_en;

  // per-distance bookkeeping
  logic [IDX_W-1:0]     best_mem [DIST_SLOTS];
  logic [IDX_W-1:0]     best_rd;
  logic                 best_rd_en;
  logic [DIST_SLOTS-1:0] seen;
  logic                 seen_clr;

  // distance unit outputs
  logic                 dist_valid;
  logic [DIST_W-1:0]    ham_dist;
  logic [IDX_W-1:0]     dist_idx;
  logic                 dist_busy;

  logic                 accept;
  logic                 res_free;
  logic                 res_load;
  logic                 full;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid & req_ready;
  assign res_free   = ~res_valid | res_ready;
  assign res_load   = ((state == S_READ) & held_valid & res_free) |
                      ((state == S_FLUSH) & res_free);
  assign full       = (entry_count >= CNT_W'(TABLE_DEPTH));
  assign wr_en      = accept & (req.func == FUNC_APPEND) & ~full;
  assign seen_clr   = accept & (req.func == FUNC_QUERY) & (entry_count != '0);
  assign rd_en      = (state == S_SCAN) & (rd_addr < entry_count);
  assign best_rd_en = (state == S_LOOK) & (slot < DIST_W'(DIST_SLOTS)) & seen[slot];

  // hash table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hash_store[entry_count[IDX_W-1:0]] <= req.hash_value;
    end
    if (rd_en) begin
      rd_data <= hash_store[rd_addr[IDX_W-1:0]];
    end
  end

  // read tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
    rd_idx <= rd_addr[IDX_W-1:0];
  end

  hnht_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (rd_valid),
    .a         (rd_data),
    .b         (query),
    .tag_in    (rd_idx),
    .valid_out (dist_valid),
    .dist_out  (ham_dist),
    .tag_out   (dist_idx),
    .busy      (dist_busy)
  );

  // latest entry per distance, later entries overwrite earlier ones
  always_ff @(posedge clk) begin
    if (dist_valid) begin
      best_mem[ham_dist] <= dist_idx;
    end
    if (best_rd_en) begin
      best_rd <= best_mem[slot];
    end
  end

  // occupied-distance flags
  always_ff @(posedge clk) begin
    if (rst || seen_clr) begin
      seen <= '0;
    end else if (dist_valid) begin
      seen[ham_dist] <= 1'b1;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
      held_valid  <= 1'b0;
      rd_addr     <= '0;
      slot        <= '0;
      n_held      <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            held.distance <= '0;
            held.last     <= 1'b1;
            case (req.func)
              FUNC_CLEAR: begin
                entry_count      <= '0;
                held.entry_index <= '0;
                held.status      <= ST_DONE_ACK;
                state            <= S_FLUSH;
              end
              FUNC_APPEND: begin
                if (full) begin
                  held.entry_index <= '0;
                  held.status      <= ST_FULL;
                end else begin
                  held.entry_index <= entry_count[IDX_W-1:0];
                  held.status      <= ST_DONE_ACK;
                  entry_count      <= entry_count + 1'b1;
                end
                state <= S_FLUSH;
              end
              FUNC_QUERY: begin
                if (entry_count == '0) begin
                  held.entry_index <= '0;
                  held.status      <= ST_NO_MATCH;
                  state            <= S_FLUSH;
                end else begin
                  query      <= req.hash_value;
                  rd_addr    <= '0;
                  slot       <= '0;
                  n_held     <= '0;
                  held_valid <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // one table read per cycle
        S_SCAN: begin
          if (rd_en) begin
            rd_addr <= rd_addr + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end

        // wait for the distance pipeline to empty
        S_DRAIN: begin
          if (!rd_valid && !dist_busy) begin
            state <= S_LOOK;
          end
        end

        // step through distance slots in ascending order
        S_LOOK: begin
          if (slot == DIST_W'(DIST_SLOTS) || n_held == CAND_W'(MAX_CANDIDATES)) begin
            held.last <= 1'b1;
            state     <= S_FLUSH;
          end else if (seen[slot]) begin
            state <= S_READ;
          end else begin
            slot <= slot + 1'b1;
          end
        end

        // push previous candidate, hold the new one
        S_READ: begin
          if (!held_valid || res_free) begin
            if (held_valid) begin
              res <= held;
            end
            held.entry_index <= best_rd;
            held.distance    <= slot;
            held.status      <= ST_MATCH;
            held.last        <= 1'b0;
            held_valid       <= 1'b1;
            n_held           <= n_held + 1'b1;
            slot             <= slot + 1'b1;
            state            <= S_LOOK;
          end
        end

        // final result of the request
        S_FLUSH: begin
          if (res_free) begin
            res        <= held;
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
